// ===== design/hsl_pkg.sv =====
// Shared types and constants for the RGB to HSL pixel converter.
// No dependencies; every other design file refers to this package by scoped names.
package hsl_pkg;

   localparam int ColorW = 8;                  // pixel component width
   localparam int SelW   = 2;                  // channel select width
   localparam int QuotW  = 8;                  // result / quotient width
   localparam int DenW   = 11;                 // divisor width, 6*c <= 1530
   localparam int RemW   = DenW + QuotW;       // dividend width, 255*num < 2^19

   localparam logic [SelW-1:0] CHAN_HUE   = 2'd0;
   localparam logic [SelW-1:0] CHAN_SAT   = 2'd1;
   localparam logic [SelW-1:0] CHAN_LIGHT = 2'd2;

   typedef struct packed {
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
   } hsl_pix_type;

   // Work item that travels down the pipe. bypass marks a result already final
   // in quot (lightness, grey pixels, unused selector); otherwise quot is built
   // one bit per divider stage from rem / den.
   typedef struct packed {
      logic             bypass;
      logic [QuotW-1:0] quot;
      logic [DenW-1:0]  den;
      logic [RemW-1:0]  rem;
   } hsl_work_type;

endpackage

// ===== design/hsl_req_if.sv =====
// Request channel: one RGB pixel per transfer, valid/ready handshake.
// Depends on hsl_pkg for the component width.
interface hsl_req_if;
   logic                      valid;
   logic                      ready;
   logic [hsl_pkg::ColorW-1:0] red;
   logic [hsl_pkg::ColorW-1:0] green;
   logic [hsl_pkg::ColorW-1:0] blue;

   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/hsl_rsp_if.sv =====
// Response channel: one selected HSL byte per transfer, valid/ready handshake.
// Depends on hsl_pkg for the result width.
interface hsl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hsl_pkg::QuotW-1:0] channel_value;

   modport source(output valid, output channel_value, input ready);
   modport sink(input valid, input channel_value, output ready);
endinterface

// ===== design/hsl_prep.sv =====
// First pipe stage: max/min, chroma, and dividend/divisor setup per channel.
// Depends on hsl_pkg.
module hsl_prep (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [hsl_pkg::SelW-1:0]  sel,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  hsl_pkg::hsl_pix_type      in_pix,
   output logic                      out_valid,
   input  logic                      out_ready,
   output hsl_pkg::hsl_work_type     out_work
);

   logic                        valid_ff;
   hsl_pkg::hsl_work_type       work_ff;
   hsl_pkg::hsl_work_type       work_in;

   logic [hsl_pkg::ColorW-1:0]  r, g, b, mx, mn, chroma;
   logic [hsl_pkg::ColorW:0]    sum;
   logic                        r_dom, g_dom;
   logic [hsl_pkg::DenW-1:0]    c6, hue_num, sat_den;

   always_comb begin
      r = in_pix.red;
      g = in_pix.green;
      b = in_pix.blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      chroma = mx - mn;
      sum    = {1'b0, mx} + {1'b0, mn};
      // first maximum wins: red, then green, then blue
      r_dom  = (r >= g) && (r >= b);
      g_dom  = !r_dom && (g >= b);
      c6     = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
      // numerators are non-negative and below 6*c; modular 11-bit math is exact
      if (r_dom) begin
         if (g >= b) hue_num = hsl_pkg::DenW'(g) - hsl_pkg::DenW'(b);
         else        hue_num = c6 - (hsl_pkg::DenW'(b) - hsl_pkg::DenW'(g));
      end else if (g_dom) begin
         hue_num = {2'b00, chroma, 1'b0} + hsl_pkg::DenW'(b) - hsl_pkg::DenW'(r);
      end else begin
         hue_num = {1'b0, chroma, 2'b00} + hsl_pkg::DenW'(r) - hsl_pkg::DenW'(g);
      end
      if (sum < 9'd255) sat_den = hsl_pkg::DenW'(sum);
      else              sat_den = hsl_pkg::DenW'(9'd510 - sum);

      work_in = '0;
      case (sel)
         hsl_pkg::CHAN_HUE: begin
            work_in.bypass = (chroma == '0);
            work_in.rem    = hsl_pkg::RemW'(hue_num);
            work_in.den    = c6;
         end
         hsl_pkg::CHAN_SAT: begin
            work_in.bypass = (chroma == '0);
            work_in.rem    = hsl_pkg::RemW'(chroma);
            work_in.den    = sat_den;
         end
         hsl_pkg::CHAN_LIGHT: begin
            work_in.bypass = 1'b1;
            work_in.quot   = sum[hsl_pkg::ColorW:1];
         end
         default: begin
            work_in.bypass = 1'b1;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== design/hsl_scale.sv =====
// Second pipe stage: scales the numerator by 255 as (n << 8) - n.
// Depends on hsl_pkg.
module hsl_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsl_pkg::hsl_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsl_pkg::hsl_work_type out_work
);

   logic                  valid_ff;
   hsl_pkg::hsl_work_type work_ff;
   hsl_pkg::hsl_work_type work_in;

   always_comb begin
      work_in     = in_work;
      work_in.rem = {in_work.rem[hsl_pkg::DenW-1:0], {hsl_pkg::QuotW{1'b0}}}
                    - hsl_pkg::RemW'(in_work.rem[hsl_pkg::DenW-1:0]);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== design/hsl_div_stage.sv =====
// One stage of the restoring divider: resolves quotient bit BIT_POS.
// Depends on hsl_pkg.
module hsl_div_stage #(
   parameter int BIT_POS = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsl_pkg::hsl_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsl_pkg::hsl_work_type out_work
);

   logic                     valid_ff;
   hsl_pkg::hsl_work_type    work_ff;
   hsl_pkg::hsl_work_type    work_in;
   logic [hsl_pkg::RemW-1:0] den_sh;
   logic [hsl_pkg::RemW:0]   diff;

   always_comb begin
      den_sh  = hsl_pkg::RemW'(in_work.den) << BIT_POS;
      diff    = {1'b0, in_work.rem} - {1'b0, den_sh};
      work_in = in_work;
      if (!in_work.bypass) begin
         work_in.quot[BIT_POS] = !diff[hsl_pkg::RemW];
         if (!diff[hsl_pkg::RemW]) begin
            work_in.rem = diff[hsl_pkg::RemW-1:0];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== design/rgb_to_hsl_pixel.sv =====
// RGB to HSL pixel converter. Takes one 8-bit RGB pixel per request and
// returns one byte: hue, saturation or lightness scaled to 0..255 and
// truncated, picked by the csr channel_select register (0 hue, 1 saturation,
// 2 lightness, 3 gives 0). Fully pipelined: one request per clock sustained
// as long as each response is taken when it is offered. The depth is
// set by the divider, a restoring divide with one quotient bit per stage
// (8 stages), behind a setup stage (max/min, chroma, numerator/denominator)
// and a x255 scale stage. Every stage holds its item under backpressure and
// bubbles are squeezed out, so a stalled response does not stop the input
// until the pipe is full. Write channel_select only while the pipe is empty.
// Depends on hsl_pkg, hsl_req_if, hsl_rsp_if, hsl_prep, hsl_scale, hsl_div_stage.
module rgb_to_hsl_pixel (
   input  logic                     clock,
   input  logic                     reset,
   hsl_req_if.sink                  req_bus,
   hsl_rsp_if.source                rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [hsl_pkg::SelW-1:0] csr_wr_data
);

   localparam int NumDiv = hsl_pkg::QuotW;

   logic [hsl_pkg::SelW-1:0] channel_select_ff;

   hsl_pkg::hsl_pix_type  req_pix;
   logic                  prep_vld, prep_rdy;
   hsl_pkg::hsl_work_type prep_work;
   logic                  scale_vld, scale_rdy;
   hsl_pkg::hsl_work_type scale_work;

   // divider chain links: index 0 feeds the MSB stage, index NumDiv is the output
   logic                  div_vld  [NumDiv+1];
   logic                  div_rdy  [NumDiv+1];
   hsl_pkg::hsl_work_type div_work [NumDiv+1];

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= hsl_pkg::CHAN_HUE;
      end else if (csr_wr_en) begin
         channel_select_ff <= csr_wr_data;
      end
   end

   assign req_pix.red   = req_bus.red;
   assign req_pix.green = req_bus.green;
   assign req_pix.blue  = req_bus.blue;

   hsl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .sel       (channel_select_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_pix    (req_pix),
      .out_valid (prep_vld),
      .out_ready (prep_rdy),
      .out_work  (prep_work)
   );

   hsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_vld),
      .in_ready  (prep_rdy),
      .in_work   (prep_work),
      .out_valid (scale_vld),
      .out_ready (scale_rdy),
      .out_work  (scale_work)
   );

   assign div_vld[0]  = scale_vld;
   assign div_work[0] = scale_work;
   assign scale_rdy   = div_rdy[0];

   // MSB first: stage i resolves quotient bit NumDiv-1-i
   for (genvar i = 0; i < NumDiv; i++) begin : g_div
      hsl_div_stage #(
         .BIT_POS (NumDiv - 1 - i)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_vld[i]),
         .in_ready  (div_rdy[i]),
         .in_work   (div_work[i]),
         .out_valid (div_vld[i+1]),
         .out_ready (div_rdy[i+1]),
         .out_work  (div_work[i+1])
      );
   end

   // last divider register doubles as the response register
   assign rsp_bus.valid         = div_vld[NumDiv];
   assign rsp_bus.channel_value = div_work[NumDiv].quot;
   assign div_rdy[NumDiv]       = rsp_bus.ready;

   // accepted request lands in the setup register
   a_req_to_prep: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> prep_vld)
      else $error("accepted request did not reach setup stage");

   // divide setup never produces a zero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      prep_vld && !prep_work.bypass |-> prep_work.den != '0)
      else $error("zero divisor entering divider");

   // quotient must fit in 8 bits: dividend below divisor << 8
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      scale_vld && !scale_work.bypass |->
         scale_work.rem < (hsl_pkg::RemW'(scale_work.den) << NumDiv))
      else $error("dividend overflows quotient range");

   // stalled item at divider entry holds its place
   a_scale_hold: assert property (@(posedge clock) disable iff (reset)
      scale_vld && !scale_rdy |=> scale_vld && $stable(scale_work))
      else $error("scale stage lost or changed a stalled item");

endmodule
